[sv/tfwc_pkg.sv]
// Shared widths, register indexes and reset values for the tone frequency
// window checker. No dependencies; compile this file first.

package tfwc_pkg;

   localparam int SampleWidth = 16;
   localparam int CountWidth  = 16;
   localparam int CsrWidth    = 16;
   localparam int CsrIdxWidth = 2;
   localparam int ScaledWidth = 19;
   localparam int DiffWidth   = ScaledWidth + 1;

   // Register indexes on the configuration port.
   localparam logic [CsrIdxWidth-1:0] RegWindowLen   = 2'd0;
   localparam logic [CsrIdxWidth-1:0] RegRiseLimit   = 2'd1;
   localparam logic [CsrIdxWidth-1:0] RegTargetCount = 2'd2;
   localparam logic [CsrIdxWidth-1:0] RegDeviation   = 2'd3;

   localparam logic [CsrWidth-1:0] WindowLenReset   = 16'd8000;
   localparam logic [CsrWidth-1:0] RiseLimitReset   = 16'd10;
   localparam logic [CsrWidth-1:0] TargetCountReset = 16'd400;
   localparam logic [CsrWidth-1:0] DeviationReset   = 16'd3;

   // Division by 33 as a multiply by ceil(2^21 / 33) and a shift. The result
   // is exact for every magnitude up to 32768.
   localparam int             RecipShift = 21;
   localparam logic [15:0]    Recip33    = 16'd63551;

   typedef logic signed [ScaledWidth-1:0] scaled_type;
   typedef logic        [CountWidth-1:0]  count_type;

endpackage

[sv/tfwc_req_if.sv]
// Sample channel of the tone frequency window checker: valid, ready and one
// signed sample. Depends on tfwc_pkg.

interface tfwc_req_if;
   logic                                     valid;
   logic                                     ready;
   logic signed [tfwc_pkg::SampleWidth-1:0]  sample;

   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);
endinterface

[sv/tfwc_rsp_if.sv]
// Result channel of the tone frequency window checker: valid, ready, the
// crossing count of a window and its in-band flag. Depends on tfwc_pkg.

interface tfwc_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [tfwc_pkg::CountWidth-1:0]   crossing_count;
   logic                              in_band;

   modport source (output valid, output crossing_count, output in_band, input ready);
   modport sink   (input valid, input crossing_count, input in_band, output ready);
endinterface

[sv/tone_frequency_window_checker.sv]
// Top level of the tone frequency window checker: scaling stage, crossing
// detector and result register. Depends on tfwc_pkg, tfwc_req_if, tfwc_rsp_if.

// The block counts rising crossings of a stream of signed converter samples
// over a window of window_len samples (zero means 65536) and, at the end of
// each window, sends one item with the count and a flag that is set when the
// count lies within target_count plus or minus deviation, inclusive. It takes
// one sample item per clock cycle while the pipeline is not stalled. A sample
// passes through two stages: the first scales it to 4*s + s/33 (one 16 by 16
// bit multiply by a reciprocal of 33), the second compares it with the
// previous scaled value, updates the detector and, at the window end, loads
// the result register, from which the result item is sent. The result
// register stalls the pipeline only while it holds an item that the sink has
// not taken; otherwise samples keep flowing. Configuration writes are meant
// to be made while no sample is in the pipeline.

module tone_frequency_window_checker (
   input  logic                                   clock,
   input  logic                                   reset,
   tfwc_req_if.sink                               req_chan,
   tfwc_rsp_if.source                             rsp_chan,
   input  logic                                   csr_we,
   input  logic [tfwc_pkg::CsrIdxWidth-1:0]       csr_index,
   input  logic [tfwc_pkg::CsrWidth-1:0]          csr_wdata
);

   // Configuration registers.
   logic [tfwc_pkg::CsrWidth-1:0] window_len_ff, rise_limit_ff;
   logic [tfwc_pkg::CsrWidth-1:0] target_count_ff, deviation_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         window_len_ff   <= tfwc_pkg::WindowLenReset;
         rise_limit_ff   <= tfwc_pkg::RiseLimitReset;
         target_count_ff <= tfwc_pkg::TargetCountReset;
         deviation_ff    <= tfwc_pkg::DeviationReset;
      end else if (csr_we) begin
         case (csr_index)
            tfwc_pkg::RegWindowLen:   window_len_ff   <= csr_wdata;
            tfwc_pkg::RegRiseLimit:   rise_limit_ff   <= csr_wdata;
            tfwc_pkg::RegTargetCount: target_count_ff <= csr_wdata;
            tfwc_pkg::RegDeviation:   deviation_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Handshake control for the two stages.
   logic scale_valid_ff, scale_valid_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic detect_go;
   logic req_take;

   assign detect_go        = scale_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready   = !scale_valid_ff || detect_go;
   assign req_take         = req_chan.valid && req_chan.ready;

   // Scaling stage: 4*s plus s/33 truncated toward zero. The quotient is
   // formed on the magnitude and then given the sample's sign.
   logic [15:0]                       sample_mag;
   logic [31:0]                       quot_prod;
   logic [10:0]                       quot_mag;
   tfwc_pkg::scaled_type              quot_signed;
   tfwc_pkg::scaled_type              scaled_in, scaled_ff;

   always_comb begin
      sample_mag  = req_chan.sample[15] ? (16'd0 - req_chan.sample) : req_chan.sample;
      quot_prod   = {16'd0, sample_mag} * {16'd0, tfwc_pkg::Recip33};
      quot_mag    = quot_prod[tfwc_pkg::RecipShift +: 11];
      quot_signed = req_chan.sample[15]
                    ? (19'sd0 - tfwc_pkg::scaled_type'({8'd0, quot_mag}))
                    : tfwc_pkg::scaled_type'({8'd0, quot_mag});
      scaled_in   = tfwc_pkg::scaled_type'({{3{req_chan.sample[15]}}, req_chan.sample})
                    * 19'sd4 + quot_signed;
      scale_valid_in = req_take ? 1'b1 : (detect_go ? 1'b0 : scale_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_valid_ff <= 1'b0;
      end else begin
         scale_valid_ff <= scale_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         scaled_ff <= scaled_in;
      end
   end

   // Detector stage: window state and the rise test.
   tfwc_pkg::scaled_type             prev_scaled_ff, prev_scaled_in;
   logic                             armed_ff, armed_in;
   tfwc_pkg::count_type              rise_count_ff, rise_count_in;
   tfwc_pkg::count_type              sample_index_ff, sample_index_in;
   logic signed [tfwc_pkg::DiffWidth-1:0] diff;
   logic                             rearm;
   logic                             rise_hit;
   tfwc_pkg::count_type              count_next;
   logic [16:0]                      taken;
   logic [16:0]                      win_len;
   logic                             window_end;
   logic [16:0]                      band_hi;
   logic [16:0]                      count_plus_dev;
   logic                             band_ok;
   tfwc_pkg::count_type              crossing_count_ff;
   logic                             in_band_ff;

   always_comb begin
      diff = {scaled_ff[18], scaled_ff} - {prev_scaled_ff[18], prev_scaled_ff};
      // A fall re-arms; a large enough rise while armed counts once.
      rearm    = diff[tfwc_pkg::DiffWidth-1] || armed_ff;
      rise_hit = rearm && (diff > $signed({4'd0, rise_limit_ff}));
      count_next = (rise_hit && (rise_count_ff != 16'hFFFF))
                   ? rise_count_ff + 16'd1 : rise_count_ff;

      taken      = {1'b0, sample_index_ff} + 17'd1;
      win_len    = (window_len_ff == 16'd0) ? 17'h10000 : {1'b0, window_len_ff};
      window_end = taken >= win_len;

      // Band test without wrap: count <= target + dev and count + dev >= target.
      band_hi        = {1'b0, target_count_ff} + {1'b0, deviation_ff};
      count_plus_dev = {1'b0, count_next} + {1'b0, deviation_ff};
      band_ok        = ({1'b0, count_next} <= band_hi)
                       && (count_plus_dev >= {1'b0, target_count_ff});

      prev_scaled_in  = prev_scaled_ff;
      armed_in        = armed_ff;
      rise_count_in   = rise_count_ff;
      sample_index_in = sample_index_ff;
      if (detect_go) begin
         if (window_end) begin
            prev_scaled_in  = '0;
            armed_in        = 1'b1;
            rise_count_in   = '0;
            sample_index_in = '0;
         end else begin
            prev_scaled_in  = scaled_ff;
            armed_in        = rearm && !rise_hit;
            rise_count_in   = count_next;
            sample_index_in = taken[15:0];
         end
      end

      if (detect_go && window_end) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_scaled_ff  <= '0;
         armed_ff        <= 1'b1;
         rise_count_ff   <= '0;
         sample_index_ff <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         prev_scaled_ff  <= prev_scaled_in;
         armed_ff        <= armed_in;
         rise_count_ff   <= rise_count_in;
         sample_index_ff <= sample_index_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   // Result register, loaded when a window closes.
   always_ff @(posedge clock) begin
      if (detect_go && window_end) begin
         crossing_count_ff <= count_next;
         in_band_ff        <= band_ok;
      end
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.crossing_count = crossing_count_ff;
   assign rsp_chan.in_band        = in_band_ff;

endmodule
